@@ hw/rtl/npm_pkg.sv @@
// Shared types, opcodes and default sizes for the NFA prefix matcher.
`default_nettype none

package npm_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int NUM_STATES_DEF    = 8;
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int LEN_BITS_DEF      = 16;

    // Fixed widths of the transaction fields.
    localparam int OUT_LEN_W = 16;
    localparam int CFG_W     = 8;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_WRITE   = 2'd1,
        OP_SYMBOL  = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] symbol_code;
        logic [2:0] from_state;
        logic [7:0] next_mask;
    } item_t;

    typedef struct packed {
        logic                 accepted_now;
        logic                 halted;
        logic [OUT_LEN_W-1:0] consumed_len;
        logic [OUT_LEN_W-1:0] shortest_len;
        logic                 shortest_valid;
        logic [OUT_LEN_W-1:0] longest_len;
        logic                 longest_valid;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/nfa_prefix_matcher.sv @@
// Top level of the NFA prefix matcher: accept-mask register and the three stages.
`default_nettype none

// The matcher runs a nondeterministic finite automaton of up to NUM_STATES
// states over a stream of symbols, keeping the active states as one bit each.
// Every input transaction yields exactly one result transaction, in order: a
// restart transaction makes state 0 the only active state and clears the
// lengths, a write transaction loads the next-state mask of one (symbol, state)
// pair into the transition memory, a symbol transaction replaces the active set
// by the union of the masks of all active states for that symbol, and the no
// operation code just reports the current status. Each result gives whether the
// automaton accepts now, whether it has halted, the symbols consumed since the
// restart and the first and latest accepted prefix lengths; lengths saturate at
// 2^LEN_BITS - 1 and symbols after a halt are ignored. The block takes one
// transaction per clock cycle for as long as the result side does not stall;
// a result passes the front end's fetch registers, the queue and the output
// register before it is presented. The front end reads one transition memory
// row per transaction through a registered read port, and a two-entry queue
// feeds the back end, which steps the active set in combinational logic and
// holds the result in an output register. The transition memory needs no
// clearing pass: a valid bit per row makes rows never written read as zero,
// so the block is ready straight out of reset. The user must write the accept
// mask through cfg_wr_en and cfg_wr_data only while the block is idle; the
// block itself does not enforce this.

module nfa_prefix_matcher #(
    parameter int NUM_STATES    = npm_pkg::NUM_STATES_DEF,
    parameter int ALPHABET_SIZE = npm_pkg::ALPHABET_SIZE_DEF,
    parameter int LEN_BITS      = npm_pkg::LEN_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [npm_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire npm_pkg::item_t            item,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output npm_pkg::result_t               result
);

    localparam int Q_W = npm_pkg::OP_W + NUM_STATES * NUM_STATES;

    // Accept mask: one bit per state, set for an accepting state.
    logic [npm_pkg::CFG_W-1:0] accept_mask_reg;

    logic           push;
    logic [Q_W-1:0] push_data;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    logic [Q_W-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            accept_mask_reg <= cfg_wr_data;
        end
    end

    // Front end: takes transactions, performs writes and fetches the symbol row.
    npm_front #(
        .NUM_STATES    (NUM_STATES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    // The queue lets the front keep taking transactions while the result waits.
    npm_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    // Back end: steps the automaton and forms the result transaction.
    npm_back #(
        .NUM_STATES (NUM_STATES),
        .LEN_BITS   (LEN_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept_mask  (accept_mask_reg[NUM_STATES-1:0]),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/npm_front.sv @@
// Front end: accepts transactions, owns the transition memory and fetches rows.
`default_nettype none

module npm_front #(
    parameter int NUM_STATES    = npm_pkg::NUM_STATES_DEF,
    parameter int ALPHABET_SIZE = npm_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       item_valid,
    output logic                                            item_stall,
    input  wire npm_pkg::item_t                             item,
    output logic                                            push,
    output logic [npm_pkg::OP_W+NUM_STATES*NUM_STATES-1:0]  push_data,
    input  wire logic                                       q_full
);

    localparam int WORD_W  = NUM_STATES * NUM_STATES;
    localparam int SYM_AW  = $clog2(ALPHABET_SIZE);
    localparam int STATE_W = $clog2(NUM_STATES);

    logic [WORD_W-1:0]        mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] row_valid_reg;

    logic                     f_valid_reg;
    logic                     f_valid_next;
    npm_pkg::opcode_t         f_op_reg;
    logic                     f_row_ok_reg;
    logic [WORD_W-1:0]        rd_word_reg;

    logic                     accept;
    logic                     sym_ok;
    logic                     from_ok;
    logic                     wr_en;
    logic [SYM_AW-1:0]        addr;
    logic [STATE_W-1:0]       from_idx;

    assign item_stall = f_valid_reg && q_full;
    assign accept     = item_valid && !item_stall;
    assign addr       = item.symbol_code[SYM_AW-1:0];
    assign from_idx   = item.from_state[STATE_W-1:0];
    assign sym_ok     = (9'(item.symbol_code) < 9'(ALPHABET_SIZE));
    assign from_ok    = (4'(item.from_state) < 4'(NUM_STATES));
    assign wr_en      = accept && (item.opcode == npm_pkg::OP_WRITE) && sym_ok && from_ok;

    assign push      = f_valid_reg && !q_full;
    assign push_data = {f_op_reg, (f_row_ok_reg ? rd_word_reg : {WORD_W{1'b0}})};

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    // A row that has never been written is filled in whole on its first write,
    // so the masks of the other states start out as zero.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < NUM_STATES; b++)
            begin
                if (STATE_W'(b) == from_idx)
                begin
                    mem[addr][b*NUM_STATES +: NUM_STATES] <= item.next_mask[NUM_STATES-1:0];
                end
                else if (!row_valid_reg[addr])
                begin
                    mem[addr][b*NUM_STATES +: NUM_STATES] <= '0;
                end
            end
        end
        if (accept)
        begin
            rd_word_reg  <= mem[addr];
            f_op_reg     <= item.opcode;
            f_row_ok_reg <= sym_ok && row_valid_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            f_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[addr] <= 1'b1;
            end
            f_valid_reg <= f_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/npm_queue.sv @@
// Two-entry queue between the front end and the back end.
`default_nettype none

module npm_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'(DEPTH));
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid |-> !pop)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/npm_back.sv @@
// Back end: steps the active state set, keeps the lengths and holds the result.
`default_nettype none

module npm_back #(
    parameter int NUM_STATES = npm_pkg::NUM_STATES_DEF,
    parameter int LEN_BITS   = npm_pkg::LEN_BITS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic [NUM_STATES-1:0]                      accept_mask,
    input  wire logic                                       q_valid,
    input  wire logic [npm_pkg::OP_W+NUM_STATES*NUM_STATES-1:0] q_data,
    output logic                                            pop,
    output logic                                            result_valid,
    input  wire logic                                       result_stall,
    output npm_pkg::result_t                                result
);

    localparam int WORD_W = NUM_STATES * NUM_STATES;
    localparam int OW     = npm_pkg::OUT_LEN_W;

    logic [NUM_STATES-1:0] act_reg;
    logic [NUM_STATES-1:0] act_next;
    logic [LEN_BITS-1:0]   len_reg;
    logic [LEN_BITS-1:0]   len_next;
    logic [LEN_BITS-1:0]   first_len_reg;
    logic [LEN_BITS-1:0]   first_len_next;
    logic                  first_seen_reg;
    logic                  first_seen_next;
    logic [LEN_BITS-1:0]   last_len_reg;
    logic [LEN_BITS-1:0]   last_len_next;
    logic                  last_seen_reg;
    logic                  last_seen_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    npm_pkg::result_t      out_item_reg;
    npm_pkg::result_t      out_item_next;

    npm_pkg::opcode_t      op;
    logic [WORD_W-1:0]     word;
    logic [NUM_STATES-1:0] gather;
    logic                  stepped;
    logic                  accepting;

    assign pop          = q_valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    always_comb
    begin
        op   = npm_pkg::opcode_t'(q_data[WORD_W +: npm_pkg::OP_W]);
        word = q_data[WORD_W-1:0];

        gather = '0;
        for (int s = 0; s < NUM_STATES; s++)
        begin
            if (act_reg[s])
            begin
                gather = gather | word[s*NUM_STATES +: NUM_STATES];
            end
        end

        act_next        = act_reg;
        len_next        = len_reg;
        first_len_next  = first_len_reg;
        first_seen_next = first_seen_reg;
        last_len_next   = last_len_reg;
        last_seen_next  = last_seen_reg;
        stepped         = 1'b0;

        case (op)
            npm_pkg::OP_RESTART:
            begin
                act_next        = NUM_STATES'(1);
                len_next        = '0;
                first_len_next  = '0;
                first_seen_next = 1'b0;
                last_len_next   = '0;
                last_seen_next  = 1'b0;
                stepped         = 1'b1;
            end
            npm_pkg::OP_SYMBOL:
            begin
                // Once halted, further symbols leave everything as it is.
                if (act_reg != '0)
                begin
                    act_next = gather;
                    if (len_reg != {LEN_BITS{1'b1}})
                    begin
                        len_next = len_reg + LEN_BITS'(1);
                    end
                    stepped = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        accepting = |(act_next & accept_mask);
        if (stepped && accepting)
        begin
            if (!first_seen_next)
            begin
                first_seen_next = 1'b1;
                first_len_next  = len_next;
            end
            last_seen_next = 1'b1;
            last_len_next  = len_next;
        end

        out_item_next.accepted_now   = accepting;
        out_item_next.halted         = (act_next == '0);
        out_item_next.consumed_len   = OW'(len_next);
        out_item_next.shortest_len   = first_seen_next ? OW'(first_len_next) : '0;
        out_item_next.shortest_valid = first_seen_next;
        out_item_next.longest_len    = last_seen_next ? OW'(last_len_next) : '0;
        out_item_next.longest_valid  = last_seen_next;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= NUM_STATES'(1);
            len_reg        <= '0;
            first_len_reg  <= '0;
            first_seen_reg <= 1'b0;
            last_len_reg   <= '0;
            last_seen_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                act_reg        <= act_next;
                len_reg        <= len_next;
                first_len_reg  <= first_len_next;
                first_seen_reg <= first_seen_next;
                last_len_reg   <= last_len_next;
                last_seen_reg  <= last_seen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_not_accepting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.halted) |-> !out_item_reg.accepted_now)
        else $error("halted result reports acceptance");

    a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_item_reg.shortest_valid == out_item_reg.longest_valid)
                           && (out_item_reg.shortest_len <= out_item_reg.longest_len)))
        else $error("shortest and longest prefix disagree");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (op == npm_pkg::OP_SYMBOL) && (act_reg == '0)) |=> (act_reg == '0))
        else $error("symbol revived a halted automaton");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("stalled result was overwritten");
`endif

endmodule

`default_nettype wire
